@@ rtl/isq_pkg.sv @@
// ----------------------------------------------------------------------------
// isq_pkg
// Shared types, codes and sizes of the indexed sequence store.
// ----------------------------------------------------------------------------
package isq_pkg;

	// storage size and derived widths
	localparam int CAPACITY = 64;
	localparam int DATA_W   = 32;
	localparam int POS_W    = 7;
	localparam int LEN_W    = 7;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

	// read-out tree: groups of eight cells
	localparam int GRP_SIZE = 8;
	localparam int NUM_GRPS = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;

	typedef enum logic [2:0] {
		ACT_INSERT = 3'd0,
		ACT_ERASE  = 3'd1,
		ACT_GET    = 3'd2,
		ACT_SET    = 3'd3,
		ACT_SIZE   = 3'd4
	} action_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_ERASE,
		S_READ,
		S_READOUT
	} state_t;

	// per-cycle command broadcast to every cell
	typedef enum logic [1:0] {
		OP_HOLD,
		OP_INS,
		OP_DEL,
		OP_SET
	} cell_op_t;

	typedef struct packed {
		cell_op_t                  op;
		logic [CMP_W-1:0]          pos;
		logic signed [DATA_W-1:0]  value;
	} cell_cmd_t;

endpackage

@@ rtl/isq_if.sv @@
// ----------------------------------------------------------------------------
// isq_req_if / isq_rsp_if
// Valid/ready channels for requests and responses of the sequence store.
// ----------------------------------------------------------------------------
interface isq_req_if;
	logic                             valid;
	logic                             ready;
	logic [2:0]                       action;
	logic [isq_pkg::POS_W-1:0]        position;
	logic [isq_pkg::POS_W-1:0]        count;
	logic signed [isq_pkg::DATA_W-1:0] value;

	modport source (output valid, action, position, count, value, input ready);
	modport sink   (input valid, action, position, count, value, output ready);
endinterface

interface isq_rsp_if;
	logic                              valid;
	logic                              ready;
	logic signed [isq_pkg::DATA_W-1:0] read_value;
	logic [isq_pkg::LEN_W-1:0]         length;
	logic [1:0]                        status;

	modport source (output valid, read_value, length, status, input ready);
	modport sink   (input valid, read_value, length, status, output ready);
endinterface

@@ rtl/isq_cell.sv @@
// ----------------------------------------------------------------------------
// isq_cell
// One element slot of the chain; shifts up on insert, down on erase.
// ----------------------------------------------------------------------------
module isq_cell (
	input  logic                             clk,
	input  isq_pkg::cell_cmd_t               cmd,
	input  logic [isq_pkg::IDX_W-1:0]        idx,
	input  logic signed [isq_pkg::DATA_W-1:0] left_data,
	input  logic signed [isq_pkg::DATA_W-1:0] right_data,
	output logic signed [isq_pkg::DATA_W-1:0] data,
	output logic signed [isq_pkg::DATA_W-1:0] hit_data
);

	logic signed [isq_pkg::DATA_W-1:0] data_q;
	logic [isq_pkg::CMP_W-1:0]         idx_ext;
	logic                              at_pos;
	logic                              above_pos;

	assign idx_ext   = isq_pkg::CMP_W'(idx);
	assign at_pos    = (idx_ext == cmd.pos);
	assign above_pos = (idx_ext > cmd.pos);

	// element register
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			isq_pkg::OP_INS: begin
				if (above_pos) begin
					data_q <= left_data;
				end else if (at_pos) begin
					data_q <= cmd.value;
				end
			end
			isq_pkg::OP_DEL: begin
				if (at_pos || above_pos) begin
					data_q <= right_data;
				end
			end
			isq_pkg::OP_SET: begin
				if (at_pos) begin
					data_q <= cmd.value;
				end
			end
			default: begin
			end
		endcase
	end

	assign data     = data_q;
	// only the addressed cell contributes to the read-out tree
	assign hit_data = at_pos ? data_q : '0;

endmodule

@@ rtl/isq_read_tree.sv @@
// ----------------------------------------------------------------------------
// isq_read_tree
// Two-level OR tree collecting the addressed cell's value, one register level.
// ----------------------------------------------------------------------------
module isq_read_tree (
	input  logic                                                clk,
	input  logic [isq_pkg::CAPACITY-1:0][isq_pkg::DATA_W-1:0]   hits,
	output logic signed [isq_pkg::DATA_W-1:0]                   result
);

	logic [isq_pkg::NUM_GRPS-1:0][isq_pkg::DATA_W-1:0] grp_s1;

	// first level: OR within each group of eight, registered
	always_ff @(posedge clk) begin
		for (int g = 0; g < isq_pkg::NUM_GRPS; g++) begin
			logic [isq_pkg::DATA_W-1:0] acc;
			acc = '0;
			for (int k = 0; k < isq_pkg::GRP_SIZE; k++) begin
				if (g * isq_pkg::GRP_SIZE + k < isq_pkg::CAPACITY) begin
					acc = acc | hits[g * isq_pkg::GRP_SIZE + k];
				end
			end
			grp_s1[g] <= acc;
		end
	end

	// second level: OR across groups
	always_comb begin
		logic [isq_pkg::DATA_W-1:0] acc;
		acc = '0;
		for (int g = 0; g < isq_pkg::NUM_GRPS; g++) begin
			acc = acc | grp_s1[g];
		end
		result = acc;
	end

endmodule

@@ rtl/indexed_sequence_store.sv @@
// ----------------------------------------------------------------------------
// indexed_sequence_store
// Ordered store of signed 32-bit values held in a chain of cells.
// ----------------------------------------------------------------------------
//  channel | dir | handshake    | payload
//  req     | in  | valid/ready  | action, position, count, value
//  rsp     | out | valid/ready  | read_value, length, status
//
//  Insert, set, size, zero-count erase, rejected items: answered next cycle.
//  Get: S_READ, S_READOUT (addressed cell, then the registered tree groups).
//  Erase: S_ERASE shifts the chain down by one per removed element.
//  One item at a time: req.ready is high only when idle and the response
//  register is empty. A stalled response holds until taken.
//  arst_n clears the length and the control state; cell contents are not reset.
// ----------------------------------------------------------------------------
module indexed_sequence_store (
	input  logic        clk,
	input  logic        arst_n,
	isq_req_if.sink     req,
	isq_rsp_if.source   rsp
);

	localparam int CAP = isq_pkg::CAPACITY;

	isq_pkg::state_t                    state_q, state_d;
	logic [isq_pkg::CNT_W-1:0]          cnt_q, cnt_d;
	logic [isq_pkg::CMP_W-1:0]          run_q, run_d;
	logic [isq_pkg::CMP_W-1:0]          pos_q;

	logic                               rsp_valid_q;
	logic signed [isq_pkg::DATA_W-1:0]  read_value_q;
	logic [isq_pkg::LEN_W-1:0]          length_q;
	isq_pkg::status_t                   status_q;

	logic                               res_load;
	logic signed [isq_pkg::DATA_W-1:0]  res_value;
	isq_pkg::status_t                   res_status;

	isq_pkg::cell_cmd_t                 cmd;
	logic                               req_acc;
	logic [isq_pkg::CMP_W-1:0]          pos_ext, cnt_in_ext, cnt_ext, avail, run_in;
	logic                               pos_past, pos_bad, is_full;
	isq_pkg::action_t                   act;

	logic [CAP-1:0][isq_pkg::DATA_W-1:0] cell_data;
	logic [CAP-1:0][isq_pkg::DATA_W-1:0] cell_hits;
	logic signed [isq_pkg::DATA_W-1:0]   tree_result;

	// request decode
	assign req.ready  = (state_q == isq_pkg::S_IDLE) && !rsp_valid_q;
	assign req_acc    = req.valid && req.ready;
	assign act        = isq_pkg::action_t'(req.action);
	assign pos_ext    = isq_pkg::CMP_W'(req.position);
	assign cnt_in_ext = isq_pkg::CMP_W'(req.count);
	assign cnt_ext    = isq_pkg::CMP_W'(cnt_q);
	assign pos_past   = pos_ext > cnt_ext;
	assign pos_bad    = pos_ext >= cnt_ext;
	assign is_full    = cnt_ext == isq_pkg::CMP_W'(CAP);
	assign avail      = cnt_ext - pos_ext;
	assign run_in     = (cnt_in_ext < avail) ? cnt_in_ext : avail;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			isq_pkg::S_IDLE: begin
				if (req_acc) begin
					if (act == isq_pkg::ACT_ERASE && !pos_bad && cnt_in_ext != '0) begin
						state_d = isq_pkg::S_ERASE;
					end else if (act == isq_pkg::ACT_GET && !pos_bad) begin
						state_d = isq_pkg::S_READ;
					end
				end
			end
			isq_pkg::S_ERASE: begin
				if (run_q == isq_pkg::CMP_W'(1)) begin
					state_d = isq_pkg::S_IDLE;
				end
			end
			isq_pkg::S_READ:    state_d = isq_pkg::S_READOUT;
			isq_pkg::S_READOUT: state_d = isq_pkg::S_IDLE;
			default:            state_d = isq_pkg::S_IDLE;
		endcase
	end

	// cell commands, length update and response load
	always_comb begin
		cmd.op     = isq_pkg::OP_HOLD;
		cmd.pos    = pos_q;
		cmd.value  = req.value;
		cnt_d      = cnt_q;
		run_d      = run_q;
		res_load   = 1'b0;
		res_value  = '0;
		res_status = isq_pkg::ST_OK;
		unique case (state_q)
			isq_pkg::S_IDLE: begin
				cmd.pos = pos_ext;
				run_d   = run_in;
				if (req_acc) begin
					unique case (act)
						isq_pkg::ACT_INSERT: begin
							if (pos_past) begin
								res_status = isq_pkg::ST_RANGE;
							end else if (is_full) begin
								res_status = isq_pkg::ST_FULL;
							end else begin
								cmd.op = isq_pkg::OP_INS;
								cnt_d  = cnt_q + isq_pkg::CNT_W'(1);
							end
							res_load = 1'b1;
						end
						isq_pkg::ACT_ERASE: begin
							if (pos_bad) begin
								res_status = isq_pkg::ST_RANGE;
								res_load   = 1'b1;
							end else if (cnt_in_ext == '0) begin
								res_load = 1'b1;
							end
						end
						isq_pkg::ACT_GET: begin
							if (pos_bad) begin
								res_status = isq_pkg::ST_RANGE;
								res_load   = 1'b1;
							end
						end
						isq_pkg::ACT_SET: begin
							if (pos_bad) begin
								res_status = isq_pkg::ST_RANGE;
							end else begin
								cmd.op = isq_pkg::OP_SET;
							end
							res_load = 1'b1;
						end
						default: begin
							res_load = 1'b1;
						end
					endcase
				end
			end
			isq_pkg::S_ERASE: begin
				// shift the tail down by one each cycle
				cmd.op = isq_pkg::OP_DEL;
				cnt_d  = cnt_q - isq_pkg::CNT_W'(1);
				run_d  = run_q - isq_pkg::CMP_W'(1);
				if (run_q == isq_pkg::CMP_W'(1)) begin
					res_load = 1'b1;
				end
			end
			isq_pkg::S_READ: begin
			end
			isq_pkg::S_READOUT: begin
				res_load  = 1'b1;
				res_value = tree_result;
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= isq_pkg::S_IDLE;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (res_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		run_q <= run_d;
		if (req_acc) begin
			pos_q <= pos_ext;
		end
		if (res_load) begin
			read_value_q <= res_value;
			length_q     <= isq_pkg::LEN_W'(isq_pkg::CMP_W'(cnt_d));
			status_q     <= res_status;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.read_value = read_value_q;
	assign rsp.length     = length_q;
	assign rsp.status     = status_q;

	// chain of element cells
	for (genvar i = 0; i < CAP; i++) begin : g_cell
		logic signed [isq_pkg::DATA_W-1:0] left_d, right_d;
		if (i == 0) begin : g_first
			assign left_d = '0;
		end else begin : g_left
			assign left_d = cell_data[i-1];
		end
		if (i == CAP - 1) begin : g_last
			assign right_d = '0;
		end else begin : g_right
			assign right_d = cell_data[i+1];
		end
		isq_cell u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.idx        (isq_pkg::IDX_W'(i)),
			.left_data  (left_d),
			.right_data (right_d),
			.data       (cell_data[i]),
			.hit_data   (cell_hits[i])
		);
	end

	isq_read_tree u_read_tree (
		.clk    (clk),
		.hits   (cell_hits),
		.result (tree_result)
	);

	// length never exceeds the capacity
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		isq_pkg::CMP_W'(cnt_q) <= isq_pkg::CMP_W'(CAP))
		else $error("element count beyond capacity");

	// no response pending while the chain is still shifting
	a_erase_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == isq_pkg::S_ERASE) |-> !rsp_valid_q)
		else $error("response raised during erase");

	// an accepted item always leaves a response or a busy state behind
	a_acc_progress: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> (rsp_valid_q || state_q != isq_pkg::S_IDLE))
		else $error("accepted item produced no progress");

	// erase steps shrink the length by one
	a_erase_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == isq_pkg::S_ERASE) |=> (cnt_q == $past(cnt_q) - isq_pkg::CNT_W'(1)))
		else $error("erase step did not shrink the length");

endmodule
